[rtl/core/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// when ante holds at a clock edge, cons holds at the same edge
`define SED_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sed assertion failed");

// when ante holds at a clock edge, cons holds at the next edge
`define SED_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sed assertion failed");

`endif

[rtl/core/sed_pkg.sv]
package sed_pkg;

    localparam int CHAR_W     = 8;
    localparam int LEN_W      = 11;
    localparam int MAX_LENGTH = 1024;
    localparam int LEN_FIELD_MAX = (1 << LEN_W) - 1;
    localparam int LEN_LIMIT  = (MAX_LENGTH < LEN_FIELD_MAX) ? MAX_LENGTH : LEN_FIELD_MAX;
    localparam int OUT_DATA_W = ((CHAR_W + LEN_W + 7) / 8) * 8;
    localparam int PAD_W      = OUT_DATA_W - CHAR_W - LEN_W;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_X     = 8'h78;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_BODY = 3'd1,
        PH_ESC  = 3'd2,
        PH_HEX1 = 3'd3,
        PH_HEX2 = 3'd4
    } phase_t;

    typedef struct packed {
        logic [CHAR_W-1:0] out_byte;
        logic              out_valid;
        logic              string_done;
        logic [LEN_W-1:0]  string_length;
    } result_t;

    // hex digit value; space and any non-hex character give zero
    function automatic logic [3:0] hex_nibble(input logic [CHAR_W-1:0] c);
        logic [3:0] n;
        n = 4'd0;
        if (c inside {[8'h30:8'h39]})
            n = c[3:0];
        else if (c inside {[8'h61:8'h66], [8'h41:8'h46]})
            n = c[3:0] + 4'd9;
        return n;
    endfunction

    // single-character escapes
    function automatic logic [CHAR_W-1:0] escape_map(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] b;
        case (c)
            8'h30:   b = 8'h00;   // 0
            8'h61:   b = 8'h07;   // a
            8'h62:   b = 8'h08;   // b
            8'h66:   b = 8'h0C;   // f
            8'h6E:   b = 8'h0A;   // n
            8'h72:   b = 8'h0D;   // r
            8'h74:   b = 8'h09;   // t
            8'h76:   b = 8'h0B;   // v
            default: b = c;
        endcase
        return b;
    endfunction

endpackage

[rtl/core/sed_in_reg.sv]
module sed_in_reg
    import sed_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [CHAR_W-1:0] s_char,
    input  logic              down_ready,
    output logic              hold_valid,
    output logic [CHAR_W-1:0] hold_char
);

    logic              valid_reg;
    logic              valid_next;
    logic [CHAR_W-1:0] char_reg;
    logic              accept;

    assign s_tready   = !valid_reg || down_ready;
    assign accept     = s_tvalid && s_tready;
    assign valid_next = accept || (valid_reg && !down_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            char_reg <= s_char;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_char  = char_reg;

endmodule

[rtl/core/sed_core.sv]
module sed_core
    import sed_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [CHAR_W-1:0] char_in,
    output result_t           res
);

    phase_t           phase_reg;
    phase_t           phase_next;
    logic             quoted_reg;
    logic             quoted_next;
    logic [3:0]       hex_reg;
    logic [3:0]       hex_next;
    logic [LEN_W-1:0] count_reg;
    logic [LEN_W-1:0] count_next;

    logic             idle;
    logic             open_quote;
    logic             is_nul;
    logic             qm;
    logic [LEN_W-1:0] cnt;
    phase_t           ph;
    logic [CHAR_W-1:0] byte_val;
    logic             valid;
    logic             done;

    assign idle       = (phase_reg == PH_IDLE);
    assign open_quote = idle && (char_in == CH_DQUOTE);
    assign is_nul     = (char_in == CH_NUL);
    assign qm         = idle ? 1'b0 : quoted_reg;
    assign cnt        = idle ? '0 : count_reg;
    assign ph         = idle ? PH_BODY : phase_reg;

    // next phase
    always_comb
    begin
        phase_next = ph;
        if (open_quote)
            phase_next = PH_BODY;
        else if (is_nul)
            phase_next = PH_IDLE;
        else
        begin
            case (ph)
                PH_BODY:
                begin
                    if (qm && char_in == CH_DQUOTE)
                        phase_next = PH_IDLE;
                    else if (char_in == CH_BSLASH)
                        phase_next = PH_ESC;
                    else
                        phase_next = PH_BODY;
                end
                PH_ESC:  phase_next = (char_in == CH_X) ? PH_HEX1 : PH_BODY;
                PH_HEX1: phase_next = PH_HEX2;
                PH_HEX2: phase_next = PH_BODY;
                default: phase_next = PH_IDLE;
            endcase
        end
    end

    // decoded byte, done flag and datapath state
    always_comb
    begin
        byte_val = '0;
        valid    = 1'b0;
        done     = 1'b0;
        hex_next = hex_reg;
        if (!open_quote)
        begin
            if (is_nul)
                done = 1'b1;
            else
            begin
                case (ph)
                    PH_BODY:
                    begin
                        if (qm && char_in == CH_DQUOTE)
                            done = 1'b1;
                        else if (char_in != CH_BSLASH)
                        begin
                            byte_val = char_in;
                            valid    = 1'b1;
                        end
                    end
                    PH_ESC:
                    begin
                        if (char_in != CH_X)
                        begin
                            byte_val = escape_map(char_in);
                            valid    = 1'b1;
                        end
                    end
                    PH_HEX1: hex_next = hex_nibble(char_in);
                    PH_HEX2:
                    begin
                        byte_val = {hex_reg, hex_nibble(char_in)};
                        valid    = 1'b1;
                    end
                    default: done = 1'b0;
                endcase
            end
        end

        count_next = cnt;
        if (valid && cnt < LEN_W'(LEN_LIMIT))
            count_next = cnt + 1'b1;

        res.out_byte      = byte_val;
        res.out_valid     = valid;
        res.string_done   = done;
        res.string_length = count_next;

        quoted_next = open_quote ? 1'b1 : qm;
        if (done)
        begin
            quoted_next = 1'b0;
            hex_next    = 4'd0;
            count_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            quoted_reg <= 1'b0;
            hex_reg    <= 4'd0;
            count_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            quoted_reg <= quoted_next;
            hex_reg    <= hex_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/core/sed_out_reg.sv]
module sed_out_reg
    import sed_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  result_t               res,
    output logic                  up_ready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser,
    output logic                  m_tlast
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign up_ready   = !valid_reg || m_tready;
    assign valid_next = load || (valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, res_reg.string_length, res_reg.out_byte};
    assign m_tuser  = res_reg.out_valid;
    assign m_tlast  = res_reg.string_done;

endmodule

[rtl/core/string_escape_decoder.sv]
// an input transfer passes the input register, then the result register, to the master side
// throughput: one character per cycle while m_tready holds, set by the single decode
//   stage between the input register and the result register
// reset: rst_n low clears both stage valids and returns the decoder to idle,
//   awaiting the first character of a new string
module string_escape_decoder
    import sed_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // slave side: raw characters
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [CHAR_W-1:0]     s_tdata,   // [7:0] char_in
    // master side: one result per character
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [7:0] out_byte, [18:8] string_length, rest zero
    output logic                  m_tuser,   // [0] out_valid
    output logic                  m_tlast    // string_done
);

    logic              hold_valid;
    logic [CHAR_W-1:0] hold_char;
    logic              up_ready;
    logic              step;
    result_t           res;

    // a held character moves into the result register whenever that register frees up
    assign step = hold_valid && up_ready;

    // input register, takes a new transfer when empty or while the held one advances
    sed_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_char     (s_tdata),
        .down_ready (up_ready),
        .hold_valid (hold_valid),
        .hold_char  (hold_char)
    );

    // escape decode and string state, updated once per advancing character
    sed_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .char_in (hold_char),
        .res     (res)
    );

    // result register, parts the decode from master-side backpressure
    sed_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (step),
        .res      (res),
        .up_ready (up_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

[rtl/core/sed_checker.sv]
`include "assert_macros.svh"

module sed_checker
    import sed_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tuser,
    input logic                  m_tlast
);

    // a stalled result holds
    `SED_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // no decoded byte means a zero byte field
    `SED_ASSERT_SAME(a_byte_zero, clk, rst_n, m_tvalid && !m_tuser, m_tdata[CHAR_W-1:0] == '0)
    // length never passes the limit
    `SED_ASSERT_SAME(a_len_limit, clk, rst_n, m_tvalid, m_tdata[CHAR_W+LEN_W-1:CHAR_W] <= LEN_W'(LEN_LIMIT))
    // padding bits above the length stay zero
    `SED_ASSERT_SAME(a_pad_zero, clk, rst_n, m_tvalid, m_tdata[OUT_DATA_W-1:CHAR_W+LEN_W] == '0)
    // an empty result register always lets a new character in
    `SED_ASSERT_SAME(a_in_ready, clk, rst_n, !m_tvalid, s_tready)

endmodule

bind string_escape_decoder sed_checker u_sed_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

[test/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sed_pkg::*;

    // rough size of the whole character stream
    localparam int N_ITEMS = 1950;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [CHAR_W-1:0]     s_tdata = '0;     // [7:0] char_in
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;          // [7:0] out_byte, [18:8] string_length, rest zero
    logic                  m_tuser;          // [0] out_valid
    logic                  m_tlast;          // string_done

    string_escape_decoder i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    // characters waiting to be offered, and decoder results still owed by the block
    logic [CHAR_W-1:0] pending_chars [$];
    result_t           expected_results [$];

    // escape letters that map to control bytes or to themselves
    string esc_chars = "0abfnrtv\\'\"";
    string hex_chars = "0123456789abcdefABCDEF";

    // decoder state as the testbench tracks it
    phase_t           dec_phase  = PH_IDLE;
    logic             in_quotes  = 1'b0;
    logic [3:0]       hex_hi     = 4'd0;
    logic [LEN_W-1:0] byte_count = '0;

    int chars_sent   = 0;
    int results_seen = 0;
    int strings_seen = 0;
    int bytes_seen   = 0;
    int longest_len  = 0;
    int mismatches   = 0;
    int src_gap      = 0;
    int src_calm     = 0;
    int sink_stall   = 0;
    int sink_calm    = 0;

    // value of one hex digit; a space or any non-hex character gives zero
    function automatic logic [3:0] digit_value(input logic [CHAR_W-1:0] c);
        if (c >= "0" && c <= "9")
            return 4'(c - "0");
        if (c >= "a" && c <= "f")
            return 4'(c - "a" + 10);
        if (c >= "A" && c <= "F")
            return 4'(c - "A" + 10);
        return 4'd0;
    endfunction

    // advance the tracked decoder by one character and form its result
    function automatic result_t decode_char(input logic [CHAR_W-1:0] c);
        result_t r;
        logic    ends;
        r    = '0;
        ends = 1'b0;
        if (dec_phase == PH_IDLE)
        begin
            in_quotes  = 1'b0;
            byte_count = '0;
            dec_phase  = PH_BODY;
            // an opening quote is swallowed and yields an empty result
            if (c == CH_DQUOTE)
            begin
                in_quotes = 1'b1;
                return r;
            end
        end
        // nul terminates in every phase, dropping any half-read escape
        if (c == CH_NUL)
            ends = 1'b1;
        else
        begin
            case (dec_phase)
                PH_BODY:
                begin
                    if (in_quotes && c == CH_DQUOTE)
                        ends = 1'b1;
                    else if (c == CH_BSLASH)
                        dec_phase = PH_ESC;
                    else
                    begin
                        r.out_byte  = c;
                        r.out_valid = 1'b1;
                    end
                end
                PH_ESC:
                begin
                    if (c == CH_X)
                        dec_phase = PH_HEX1;
                    else
                    begin
                        case (c)
                            "0":     r.out_byte = 8'h00;
                            "a":     r.out_byte = 8'h07;
                            "b":     r.out_byte = 8'h08;
                            "f":     r.out_byte = 8'h0C;
                            "n":     r.out_byte = 8'h0A;
                            "r":     r.out_byte = 8'h0D;
                            "t":     r.out_byte = 8'h09;
                            "v":     r.out_byte = 8'h0B;
                            default: r.out_byte = c;
                        endcase
                        r.out_valid = 1'b1;
                        dec_phase   = PH_BODY;
                    end
                end
                PH_HEX1:
                begin
                    hex_hi    = digit_value(c);
                    dec_phase = PH_HEX2;
                end
                default:
                begin
                    r.out_byte  = {hex_hi, digit_value(c)};
                    r.out_valid = 1'b1;
                    dec_phase   = PH_BODY;
                end
            endcase
        end
        // length saturates, bytes past the limit still come out
        if (r.out_valid && byte_count < LEN_LIMIT)
            byte_count++;
        r.string_length = byte_count;
        r.string_done   = ends;
        if (ends)
        begin
            dec_phase  = PH_IDLE;
            in_quotes  = 1'b0;
            hex_hi     = 4'd0;
            byte_count = '0;
        end
        return r;
    endfunction

    // idle length: mostly none or short, a few long, with calm stretches of no idling
    function automatic int pick_gap(inout int calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if (r < 2)
        begin
            calm = $urandom_range(30, 120);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // hex digit of either case, a space, or an arbitrary non-nul character
    function automatic logic [CHAR_W-1:0] pick_hex_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return hex_chars[$urandom_range(0, hex_chars.len() - 1)];
        if (r < 8)
            return CH_SPACE;
        return 8'($urandom_range(1, 255));
    endfunction

    // one body token: literal character, single-letter escape, or hex escape
    task automatic push_token(input bit no_quote, input int escape_pct);
        logic [CHAR_W-1:0] c;
        int                kind;
        kind = $urandom_range(0, 99);
        if (kind >= escape_pct)
        begin
            do
            begin
                c = 8'($urandom_range(1, 255));
            end
            while (c == CH_BSLASH || (no_quote && c == CH_DQUOTE));
            pending_chars.push_back(c);
        end
        else if (kind >= escape_pct / 2)
        begin
            pending_chars.push_back(CH_BSLASH);
            if ($urandom_range(0, 9) < 7)
                c = esc_chars[$urandom_range(0, esc_chars.len() - 1)];
            else
            begin
                // unknown escapes copy the character through
                do
                begin
                    c = 8'($urandom_range(1, 255));
                end
                while (c == CH_X);
            end
            pending_chars.push_back(c);
        end
        else
        begin
            pending_chars.push_back(CH_BSLASH);
            pending_chars.push_back(CH_X);
            pending_chars.push_back(pick_hex_char());
            pending_chars.push_back(pick_hex_char());
        end
    endtask

    // a whole string; cut 1..3 ends it with nul after a backslash, after \x,
    // or after the first hex digit
    task automatic push_string(input bit quoted, input int n_tokens, input int cut);
        if (quoted)
            pending_chars.push_back(CH_DQUOTE);
        // a leading quote in plain mode would switch to quoted mode, keep it out
        for (int i = 0; i < n_tokens; i++)
            push_token(quoted || i == 0, 40);
        if (cut == 0)
        begin
            if (quoted && $urandom_range(0, 9) != 0)
                pending_chars.push_back(CH_DQUOTE);
            else
                pending_chars.push_back(CH_NUL);
        end
        else
        begin
            pending_chars.push_back(CH_BSLASH);
            if (cut >= 2)
                pending_chars.push_back(CH_X);
            if (cut == 3)
                pending_chars.push_back(pick_hex_char());
            pending_chars.push_back(CH_NUL);
        end
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch in %s at result %0d: expected 0x%0h, got 0x%0h",
                     what, results_seen, want_v, got_v);
    endtask

    // source side: offer queued characters, predict each one as it transfers
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_results.push_back(decode_char(s_tdata));
                chars_sent++;
            end
            // the slot is free when nothing is offered or the offer just went through
            if (!s_tvalid || s_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_chars.size() != 0)
                begin
                    s_tdata  <= pending_chars.pop_front();
                    s_tvalid <= 1'b1;
                    src_gap  = pick_gap(src_calm);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // sink side: random back-pressure, compare every result transfer with the oldest prediction
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                    note_mismatch("result with no character pending", '0, m_tdata);
                else
                begin
                    result_t want;
                    want = expected_results.pop_front();
                    if (m_tdata[CHAR_W-1:0] !== want.out_byte)
                        note_mismatch("out_byte", want.out_byte, m_tdata[CHAR_W-1:0]);
                    if (m_tuser !== want.out_valid)
                        note_mismatch("out_valid", want.out_valid, m_tuser);
                    if (m_tlast !== want.string_done)
                        note_mismatch("string_done", want.string_done, m_tlast);
                    if (m_tdata[CHAR_W +: LEN_W] !== want.string_length)
                        note_mismatch("string_length", want.string_length,
                                      m_tdata[CHAR_W +: LEN_W]);
                    if (m_tdata[OUT_DATA_W-1:CHAR_W+LEN_W] !== '0)
                        note_mismatch("tdata padding", '0, m_tdata[OUT_DATA_W-1:CHAR_W+LEN_W]);
                end
                results_seen++;
                if (m_tuser === 1'b1)
                    bytes_seen++;
                if (m_tlast === 1'b1)
                    strings_seen++;
                if (int'(m_tdata[CHAR_W +: LEN_W]) > longest_len)
                    longest_len = int'(m_tdata[CHAR_W +: LEN_W]);
                sink_stall = pick_gap(sink_calm);
            end
            if (sink_stall > 0)
            begin
                sink_stall--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        int pick;
        int n_total;
        bit long_done;

        long_done = 1'b0;

        // directed strings
        pending_chars = '{
            CH_NUL,                                          // first nul: empty plain string
            CH_DQUOTE, CH_DQUOTE,                            // empty quoted string
            8'hFF, CH_DQUOTE, CH_NUL,                        // all-ones byte, quote is data in plain mode
            CH_BSLASH, CH_X, CH_SPACE, "z", CH_NUL,          // leading escape, space and non-hex digits
            CH_DQUOTE, CH_BSLASH, CH_DQUOTE, CH_BSLASH, CH_NUL,  // escaped quote, nul inside escape
            CH_DQUOTE, CH_BSLASH, CH_X, "a", CH_NUL,         // nul after first hex digit
            CH_DQUOTE, CH_BSLASH, CH_X, CH_NUL               // nul right after \x
        };

        // random strings, one long one after the first few hundred characters
        // to push the length into saturation
        while (pending_chars.size() < N_ITEMS)
        begin
            if (!long_done && pending_chars.size() > 400)
            begin
                long_done = 1'b1;
                // a nul first closes whatever the noise left open
                pending_chars.push_back(CH_NUL);
                for (int i = 0; i < LEN_LIMIT + 24; i++)
                    push_token(i == 0, 6);
                pending_chars.push_back(CH_NUL);
            end
            pick = $urandom_range(0, 99);
            if (pick < 6)
            begin
                // raw noise over the full character range
                repeat ($urandom_range(1, 8))
                    pending_chars.push_back(8'($urandom_range(0, 255)));
            end
            else
                push_string($urandom_range(0, 1), $urandom_range(0, 12),
                            (pick < 16) ? $urandom_range(1, 3) : 0);
        end
        n_total = pending_chars.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // every character transferred, then every result back, then a short drain
        while (chars_sent != n_total)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("run covered %0d characters, %0d results, %0d strings ended, %0d bytes decoded",
                 chars_sent, results_seen, strings_seen, bytes_seen);
        $display("longest reported length %0d (limit %0d), %0d mismatches",
                 longest_len, LEN_LIMIT, mismatches);
        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    // watchdog well beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("tb NOT OK");
        $finish;
    end

endmodule
